// ===== rtl/at_response_recognizer_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef AT_RESPONSE_RECOGNIZER_CORE_ASSERT_SVH
`define AT_RESPONSE_RECOGNIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ARR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("arr check failed");

// Next-cycle implication.
`define ARR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arr check failed");

`endif

// ===== rtl/arr_pkg.sv =====
package arr_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int KIND_W        = 2;
    localparam int BYTE_W        = 8;
    localparam int PLEN_W        = 6;
    // wide enough for a run length at the largest supported depth
    localparam int CNT_W         = 7;
    localparam int ERR_W         = 16;
    localparam int POS_W         = 3;

    localparam logic [KIND_W-1:0] KIND_OK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONNECT = 2'd2;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_C  = 8'h43;
    localparam logic [BYTE_W-1:0] CH_E  = 8'h45;
    localparam logic [BYTE_W-1:0] CH_K  = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_N  = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_O  = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_R  = 8'h52;
    localparam logic [BYTE_W-1:0] CH_T  = 8'h54;

    localparam logic [POS_W-1:0] ERR_FINAL = 3'd4;
    localparam logic [POS_W-1:0] CON_FINAL = 3'd6;

    // one recognized packet, handed from the front end to the drain
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  len;
        logic              bank;
        logic [ERR_W-1:0]  err;
    } desc_t;

    function automatic logic [BYTE_W-1:0] err_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            3'd0:    c = CH_E;
            3'd1:    c = CH_R;
            3'd2:    c = CH_R;
            3'd3:    c = CH_O;
            default: c = CH_R;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] con_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            3'd0:    c = CH_C;
            3'd1:    c = CH_O;
            3'd2:    c = CH_N;
            3'd3:    c = CH_N;
            3'd4:    c = CH_E;
            3'd5:    c = CH_C;
            default: c = CH_T;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/arr_stream_if.sv =====
interface arr_rx_if;
    logic                        valid;
    logic                        ready;
    logic [arr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface arr_pkt_if;
    logic                        valid;
    logic                        ready;
    logic [arr_pkg::KIND_W-1:0]  packet_kind;
    logic [arr_pkg::BYTE_W-1:0]  data_byte;
    logic                        byte_valid;
    logic [arr_pkg::PLEN_W-1:0]  packet_length;
    logic                        last;
    logic [arr_pkg::ERR_W-1:0]   error_count;

    modport source (output valid, output packet_kind, output data_byte, output byte_valid,
                    output packet_length, output last, output error_count, input ready);
    modport sink   (input valid, input packet_kind, input data_byte, input byte_valid,
                    input packet_length, input last, input error_count, output ready);
endinterface

// ===== rtl/arr_ram.sv =====
module arr_ram #(
    parameter int WIDTH = arr_pkg::BYTE_W,
    parameter int DEPTH = 2 * arr_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/arr_front.sv =====
module arr_front #(
    parameter int DEPTH = arr_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    arr_rx_if.sink                        rx,
    input  logic                          q_full,
    output logic                          push,
    output arr_pkg::desc_t                push_desc,
    output logic                          wr_en,
    output logic [$clog2(2*DEPTH)-1:0]    wr_addr,
    output logic [arr_pkg::BYTE_W-1:0]    wr_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = $clog2(2 * DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic                        capturing_reg, capturing_next;
    logic                        o_seen_reg, o_seen_next;
    logic [arr_pkg::POS_W-1:0]   epos_reg, epos_next;
    logic [arr_pkg::POS_W-1:0]   cpos_reg, cpos_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [arr_pkg::ERR_W-1:0]   err_reg, err_next;
    logic                        bank_reg, bank_next;

    logic                        accept;
    logic [arr_pkg::BYTE_W-1:0]  b;
    logic                        cap_w;
    logic                        o_w;
    logic                        store;
    logic [FW-1:0]               fill_w;
    logic                        emit;
    logic [arr_pkg::KIND_W-1:0]  kind;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    always_comb
    begin
        cap_w  = capturing_reg || (b == arr_pkg::CH_CR);
        store  = cap_w && (fill_reg < FW'(DEPTH));
        fill_w = store ? fill_reg + FW'(1) : fill_reg;
        o_w    = o_seen_reg || (b == arr_pkg::CH_O);

        capturing_next = cap_w;
        o_seen_next    = o_w;
        epos_next      = epos_reg;
        cpos_next      = cpos_reg;
        err_next       = err_reg;
        fill_next      = fill_w;
        bank_next      = bank_reg;
        emit           = 1'b0;
        kind           = arr_pkg::KIND_OK;

        if (o_w && (b == arr_pkg::CH_K))
        begin
            emit = 1'b1;
        end
        else if (epos_reg >= arr_pkg::ERR_FINAL)
        begin
            // ERROR matcher closing; CONNECT matcher holds for this byte
            epos_next = '0;
            if (b == arr_pkg::CH_R)
            begin
                if (err_reg != {arr_pkg::ERR_W{1'b1}})
                begin
                    err_next = err_reg + arr_pkg::ERR_W'(1);
                end
                emit = 1'b1;
                kind = arr_pkg::KIND_ERROR;
            end
        end
        else
        begin
            epos_next = (b == arr_pkg::err_char(epos_reg)) ?
                        epos_reg + arr_pkg::POS_W'(1) : '0;
            if (cpos_reg >= arr_pkg::CON_FINAL)
            begin
                cpos_next = '0;
                if (b == arr_pkg::CH_T)
                begin
                    emit = 1'b1;
                    kind = arr_pkg::KIND_CONNECT;
                end
            end
            else
            begin
                cpos_next = (b == arr_pkg::con_char(cpos_reg)) ?
                            cpos_reg + arr_pkg::POS_W'(1) : '0;
            end
        end

        if (emit)
        begin
            capturing_next = 1'b0;
            o_seen_next    = 1'b0;
            fill_next      = '0;
            // next packet fills the other bank if this one stored any bytes
            bank_next      = (fill_w != '0) ? !bank_reg : bank_reg;
        end
    end

    assign push           = accept && emit;
    assign push_desc.kind = kind;
    assign push_desc.len  = arr_pkg::CNT_W'(fill_w);
    assign push_desc.bank = bank_reg;
    assign push_desc.err  = err_next;

    assign wr_en   = accept && store;
    assign wr_addr = (bank_reg ? AW'(DEPTH) : '0) + AW'(fill_reg[IW-1:0]);
    assign wr_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            o_seen_reg    <= 1'b0;
            epos_reg      <= '0;
            cpos_reg      <= '0;
            fill_reg      <= '0;
            err_reg       <= '0;
            bank_reg      <= 1'b0;
        end
        else if (accept)
        begin
            capturing_reg <= capturing_next;
            o_seen_reg    <= o_seen_next;
            epos_reg      <= epos_next;
            cpos_reg      <= cpos_next;
            fill_reg      <= fill_next;
            err_reg       <= err_next;
            bank_reg      <= bank_next;
        end
    end

endmodule

// ===== rtl/arr_queue.sv =====
module arr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  arr_pkg::desc_t  push_desc,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output arr_pkg::desc_t  head
);

    arr_pkg::desc_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/arr_back.sv =====
module arr_back #(
    parameter int DEPTH = arr_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  arr_pkg::desc_t                head,
    output logic                          pop,
    output logic                          rd_en,
    output logic [$clog2(2*DEPTH)-1:0]    rd_addr,
    input  logic [arr_pkg::BYTE_W-1:0]    rd_data,
    arr_pkt_if.source                     pkt
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = $clog2(2 * DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } back_state_t;

    back_state_t                 state_reg, state_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               rd_idx;

    logic [arr_pkg::KIND_W-1:0]  kind_reg;
    logic [arr_pkg::BYTE_W-1:0]  data_reg;
    logic                        bvalid_reg;
    logic [arr_pkg::PLEN_W-1:0]  plen_reg;
    logic                        last_reg;
    logic [arr_pkg::ERR_W-1:0]   err_reg;

    logic                        load_marker;
    logic                        load_byte;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        rd_idx      = '0;
        pop         = 1'b0;
        load_marker = 1'b0;
        load_byte   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.len == '0)
                    begin
                        load_marker = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                load_byte  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (pkt.ready)
                begin
                    if (last_reg)
                    begin
                        pop        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = idx_reg + IW'(1);
                        idx_next   = rd_idx;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = (head.bank ? AW'(DEPTH) : '0) + AW'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (load_marker)
        begin
            kind_reg   <= head.kind;
            data_reg   <= '0;
            bvalid_reg <= 1'b0;
            plen_reg   <= '0;
            last_reg   <= 1'b1;
            err_reg    <= head.err;
        end
        else if (load_byte)
        begin
            kind_reg   <= head.kind;
            data_reg   <= rd_data;
            bvalid_reg <= 1'b1;
            plen_reg   <= arr_pkg::PLEN_W'(head.len);
            last_reg   <= (arr_pkg::CNT_W'(idx_reg) + arr_pkg::CNT_W'(1) == head.len);
            err_reg    <= head.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign pkt.valid         = (state_reg == S_OUT);
    assign pkt.packet_kind   = kind_reg;
    assign pkt.data_byte     = data_reg;
    assign pkt.byte_valid    = bvalid_reg;
    assign pkt.packet_length = plen_reg;
    assign pkt.last          = last_reg;
    assign pkt.error_count   = err_reg;

endmodule

// ===== rtl/at_response_recognizer_core.sv =====
// AT response recognizer. Takes one received modem byte per request on rx and
// reports OK, ERROR and CONNECT responses on pkt as runs of the bytes captured
// since the first carriage return after the previous response (up to DEPTH
// bytes, one result each, or one empty marker result). A byte is taken while
// fewer than two recognized packets are queued, the draining one included; the
// front end then stalls until the drain retires one. The drain starts a packet
// from idle, then makes each result by a registered read of the capture RAM
// and then the output register, reading on only once the sink takes the
// current result. The capture RAM holds two banks of DEPTH bytes so the next
// response can be captured while the previous one drains.
module at_response_recognizer_core #(
    parameter int DEPTH = arr_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    arr_rx_if.sink      rx,
    arr_pkt_if.source   pkt
);

    localparam int AW = $clog2(2 * DEPTH);

    logic                        push;
    arr_pkg::desc_t              push_desc;
    logic                        pop;
    logic                        q_full;
    logic                        head_valid;
    arr_pkg::desc_t              head;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [arr_pkg::BYTE_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [arr_pkg::BYTE_W-1:0]  rd_data;

    arr_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    arr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    arr_ram #(
        .WIDTH (arr_pkg::BYTE_W),
        .DEPTH (2 * DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    arr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .pkt        (pkt)
    );

endmodule

// ===== rtl/arr_checker.sv =====
`include "at_response_recognizer_core_assert.svh"

module arr_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pkt_valid,
    input  logic                        pkt_ready,
    input  logic [arr_pkg::KIND_W-1:0]  packet_kind,
    input  logic [arr_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        byte_valid,
    input  logic [arr_pkg::PLEN_W-1:0]  packet_length,
    input  logic                        last,
    input  logic [arr_pkg::ERR_W-1:0]   error_count
);

    // empty marker is a single, closing result
    `ARR_ASSERT_IMP(a_marker_shape, pkt_valid && !byte_valid, (last && data_byte == '0 && packet_length == '0))

    // a run continues with the same kind and error count once the next byte is read
    `ARR_ASSERT_IMP(a_run_continues, pkt_valid && pkt_ready && !last, ##2 (pkt_valid && byte_valid && packet_kind == $past(packet_kind, 2) && error_count == $past(error_count, 2)))

    `ARR_ASSERT_NXT(a_result_holds, pkt_valid && !pkt_ready, pkt_valid && $stable(data_byte) && $stable(last))

endmodule

bind at_response_recognizer_core arr_checker u_arr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (pkt.valid),
    .pkt_ready     (pkt.ready),
    .packet_kind   (pkt.packet_kind),
    .data_byte     (pkt.data_byte),
    .byte_valid    (pkt.byte_valid),
    .packet_length (pkt.packet_length),
    .last          (pkt.last),
    .error_count   (pkt.error_count)
);
